/* src/kmp_pkg.sv */
// shared types and constants for the kmp substring matcher
`timescale 1ns / 1ps

package kmp_pkg;

  // default sizes
  localparam int unsigned PatternMaxDefault   = 32;
  localparam int unsigned PositionBitsDefault = 16;

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // item class decided by the front
  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } kmp_op_e;

  // one classified item in the queue
  typedef struct packed {
    kmp_op_e    op;
    logic [7:0] chr;
    logic       last;
  } kmp_item_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_FIN  = 4'b1000
  } kmp_state_e;

endpackage

/* src/kmp_front.sv */
// input side: accepts items, classifies them and queues them for the back end
`timescale 1ns / 1ps

module kmp_front
  import kmp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      cmd_i,
  input  logic [7:0] char_byte_i,
  input  logic      last_i,
  output logic      head_valid_o,
  output kmp_item_t head_o,
  input  logic      pop_i
);

  kmp_item_t            q_mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 push;
  logic                 pop;
  kmp_item_t            item;

  // classify the incoming byte
  always_comb begin
    item.op   = cmd_i ? OP_TEXT : OP_PATTERN;
    item.chr  = char_byte_i;
    item.last = last_i;
  end

  // handshake
  assign in_stall_o   = (cnt_q == QueueCntW'(QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = q_mem[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

endmodule

/* src/kmp_back.sv */
// back end: pattern store, failure table build and text scan with result register
`timescale 1ns / 1ps

module kmp_back
  import kmp_pkg::*;
#(
  parameter int unsigned PATTERN_MAX   = PatternMaxDefault,
  parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  kmp_item_t   head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] match_start_o,
  output logic [15:0] match_index_o,
  output logic        past_range_o
);

  localparam int unsigned IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned PosW = POSITION_BITS;
  localparam logic [PosW-1:0] PosLimit = {PosW{1'b1}};
  localparam logic [15:0] OutLim =
    (POSITION_BITS < 16) ? 16'((1 << POSITION_BITS) - 1) : 16'hFFFF;

  // memories
  logic [7:0]      pat_mem  [PATTERN_MAX];
  logic [IdxW-1:0] fail_mem [PATTERN_MAX];

  kmp_state_e      state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [IdxW-1:0] bpl_q, bpl_d;
  logic            ready_q, ready_d;
  logic [IdxW-1:0] matched_q, matched_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] k_q, k_d;
  kmp_op_e         op_q, op_d;
  logic [7:0]      chr_q, chr_d;
  logic            last_q, last_d;
  logic [7:0]      pat_rd_q;
  logic [IdxW-1:0] fail_rd_q;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     start_q, start_d;
  logic [15:0]     index_q, index_d;
  logic            sat_q, sat_d;

  logic            pat_we;
  logic [IdxW-1:0] pat_waddr;
  logic [7:0]      pat_wdata;
  logic            fail_we;
  logic [IdxW-1:0] fail_waddr;
  logic [IdxW-1:0] fail_wdata;
  logic [IdxW-1:0] rd_addr_p;
  logic [IdxW-1:0] rd_addr_f;

  logic [LenW-1:0] eff_len;
  logic            out_free;
  logic [PosW-1:0] start_raw;
  logic            pos_sat;
  logic            start_big;
  logic            cnt_sat;

  assign out_free = !out_valid_q || !out_stall_i;
  assign eff_len  = ready_q ? '0 : len_q;

  // match start and ordinal with saturation
  always_comb begin
    start_raw = pos_q - (PosW'(len_q) - PosW'(1));
    pos_sat   = (pos_q == PosLimit);
    start_big = (33'(start_raw) > 33'h0FFFF);
    cnt_sat   = (cnt_q == PosLimit) || (33'(cnt_q) > 33'h0FFFF);
  end

  // read addresses for one failure-link step
  assign rd_addr_p = k_q[IdxW-1:0];
  assign rd_addr_f = IdxW'(k_q - 1'b1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    bpl_d       = bpl_q;
    ready_d     = ready_q;
    matched_d   = matched_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    op_d        = op_q;
    chr_d       = chr_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    start_d     = start_q;
    index_d     = index_q;
    sat_d       = sat_q;
    pop_o       = 1'b0;
    pat_we      = 1'b0;
    pat_waddr   = eff_len[IdxW-1:0];
    pat_wdata   = head_i.chr;
    fail_we     = 1'b0;
    fail_waddr  = '0;
    fail_wdata  = '0;

    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o  = 1'b1;
          op_d   = head_i.op;
          chr_d  = head_i.chr;
          last_d = head_i.last;
          case (head_i.op)
            OP_PATTERN: begin
              // a byte after a closed pattern starts a new one
              if (ready_q) begin
                ready_d   = 1'b0;
                len_d     = '0;
                bpl_d     = '0;
                matched_d = '0;
                pos_d     = '0;
                cnt_d     = '0;
              end
              if (eff_len >= LenW'(PATTERN_MAX)) begin
                // overflow byte dropped
                if (head_i.last) begin
                  ready_d   = 1'b1;
                  matched_d = '0;
                  pos_d     = '0;
                  cnt_d     = '0;
                end
              end else begin
                pat_we = 1'b1;
                if (eff_len == '0) begin
                  fail_we    = 1'b1;
                  fail_waddr = '0;
                  fail_wdata = '0;
                  bpl_d      = '0;
                  len_d      = LenW'(1);
                  if (head_i.last) begin
                    ready_d   = 1'b1;
                    matched_d = '0;
                    pos_d     = '0;
                    cnt_d     = '0;
                  end
                end else begin
                  k_d     = LenW'(bpl_q);
                  state_d = ST_READ;
                end
              end
            end
            OP_TEXT: begin
              if (ready_q && (len_q != '0)) begin
                k_d     = LenW'(matched_q);
                state_d = ST_READ;
              end else if (head_i.last) begin
                matched_d = '0;
                pos_d     = '0;
                cnt_d     = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // one failure-link step
        if (pat_rd_q == chr_q) begin
          k_d     = k_q + 1'b1;
          state_d = ST_FIN;
        end else if (k_q == '0) begin
          state_d = ST_FIN;
        end else begin
          k_d     = LenW'(fail_rd_q);
          state_d = ST_READ;
        end
      end
      ST_FIN: begin
        case (op_q)
          OP_PATTERN: begin
            fail_we    = 1'b1;
            fail_waddr = len_q[IdxW-1:0];
            fail_wdata = k_q[IdxW-1:0];
            bpl_d      = k_q[IdxW-1:0];
            len_d      = len_q + 1'b1;
            if (last_q) begin
              ready_d   = 1'b1;
              matched_d = '0;
              pos_d     = '0;
              cnt_d     = '0;
            end
            state_d = ST_IDLE;
          end
          OP_TEXT: begin
            if (k_q == len_q) begin
              // full match: wait for a free result register
              if (out_free) begin
                out_valid_d = 1'b1;
                start_d     = (pos_sat || start_big) ? OutLim : 16'(start_raw);
                index_d     = cnt_sat ? OutLim : 16'(cnt_q);
                sat_d       = pos_sat || start_big || cnt_sat;
                if (cnt_q != PosLimit) begin
                  cnt_d = cnt_q + 1'b1;
                end
                matched_d = bpl_q;
                if (!pos_sat) begin
                  pos_d = pos_q + 1'b1;
                end
                if (last_q) begin
                  matched_d = '0;
                  pos_d     = '0;
                  cnt_d     = '0;
                end
                state_d = ST_IDLE;
              end
            end else begin
              matched_d = k_q[IdxW-1:0];
              if (!pos_sat) begin
                pos_d = pos_q + 1'b1;
              end
              if (last_q) begin
                matched_d = '0;
                pos_d     = '0;
                cnt_d     = '0;
              end
              state_d = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      bpl_q       <= '0;
      ready_q     <= 1'b0;
      matched_q   <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      bpl_q       <= bpl_d;
      ready_q     <= ready_d;
      matched_q   <= matched_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    op_q    <= op_d;
    chr_q   <= chr_d;
    last_q  <= last_d;
    start_q <= start_d;
    index_q <= index_d;
    sat_q   <= sat_d;
  end

  // pattern store
  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= pat_wdata;
    end
    pat_rd_q <= pat_mem[rd_addr_p];
  end

  // failure table
  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    fail_rd_q <= fail_mem[rd_addr_f];
  end

  assign out_valid_o   = out_valid_q;
  assign match_start_o = start_q;
  assign match_index_o = index_q;
  assign past_range_o  = sat_q;

endmodule

/* src/kmp_substring_matcher_top.sv */
// top level of the streaming kmp substring matcher
`timescale 1ns / 1ps

// Streaming substring search. The input channel (in_valid_i / in_stall_o)
// carries one byte per transfer: cmd_i = 0 appends a pattern byte, last_i
// closes the pattern; cmd_i = 1 scans a text byte, last_i ends the text.
// The output channel (out_valid_o / out_stall_i) carries one transfer per
// completed match: start position, ordinal within the text and a flag for
// saturated values.
// Bytes enter a two-entry queue and are worked off by a sequencer around
// the pattern store and failure table, each read once per cycle with a
// registered read port. A text byte or a pattern byte beyond the first
// goes through the idle, read, compare and finish states, with a further
// read and compare per failure-link step; the first pattern byte and
// dropped or ignored bytes need the idle state alone. A match result is
// registered and shows in the cycle after the sequencer finishes the byte.
// Reset clears the queue, pattern length, match state and result register;
// the stores need no clearing. A stalled result holds; the sequencer waits
// on the next match while the queue keeps taking bytes until full.

module kmp_substring_matcher_top
  import kmp_pkg::*;
#(
  parameter int unsigned PATTERN_MAX   = PatternMaxDefault,
  parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  char_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] match_start_o,
  output logic [15:0] match_index_o,
  output logic        past_range_o
);

  logic      head_valid;
  kmp_item_t head;
  logic      pop;

  // front: accept and classify
  kmp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .char_byte_i  (char_byte_i),
    .last_i       (last_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // back: build table, scan text, hold results
  kmp_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_start_o (match_start_o),
    .match_index_o (match_index_o),
    .past_range_o  (past_range_o)
  );

endmodule

/* dv/tb_kmp_substring_matcher_top.sv */
// testbench for the kmp substring matcher: directed and random streams against a predictor
`timescale 1ns / 1ps

module tb_kmp_substring_matcher_top;
  import kmp_pkg::*;

  localparam int unsigned PatMax      = PatternMaxDefault;
  localparam int unsigned PosLimit    = (1 << PositionBitsDefault) - 1;
  localparam int unsigned RandomBytes = 820;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 2_000_000;

  // one reported match
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] ordinal;
    logic        sat;
  } match_t;

  // predicts kmp matches per accepted byte and checks them in order
  class match_scoreboard;
    match_t      expected_matches[$];
    logic [7:0]  pat_bytes [PatMax];
    int unsigned fail_len [PatMax];
    int unsigned pat_len, build_k, match_len, text_pos, match_cnt;
    bit          pat_closed;
    int unsigned items_noted, bytes_used, matches_seen, sat_seen, errors;

    function void clear_text();
      match_len = 0;
      text_pos  = 0;
      match_cnt = 0;
    endfunction

    function void note_byte(kmp_op_e op, logic [7:0] chr, logic last);
      int unsigned k;
      int unsigned start;
      int unsigned ord;
      bit          sat;
      items_noted++;
      // pattern byte: extend the pattern and its failure table
      if (op == OP_PATTERN) begin
        if (pat_closed) begin
          pat_closed = 1'b0;
          pat_len    = 0;
          build_k    = 0;
          clear_text();
        end
        if (pat_len < PatMax) begin
          bytes_used++;
          pat_bytes[pat_len] = chr;
          if (pat_len == 0) begin
            fail_len[0] = 0;
            build_k     = 0;
          end else begin
            k = build_k;
            while (k > 0 && pat_bytes[k] != chr) k = fail_len[k-1];
            if (pat_bytes[k] == chr) k++;
            fail_len[pat_len] = k;
            build_k = k;
          end
          pat_len++;
        end
        if (last) begin
          pat_closed = 1'b1;
          clear_text();
        end
        return;
      end
      // text byte: advance the match against a closed pattern
      if (pat_closed && pat_len > 0) begin
        bytes_used++;
        k = match_len;
        while (k > 0 && pat_bytes[k] != chr) k = fail_len[k-1];
        if (pat_bytes[k] == chr) k++;
        if (k == pat_len) begin
          sat = 1'b0;
          if (text_pos >= PosLimit) begin
            sat   = 1'b1;
            start = PosLimit;
          end else begin
            start = text_pos - (pat_len - 1);
          end
          if (start >= PosLimit) begin
            sat   = 1'b1;
            start = PosLimit;
          end
          ord = match_cnt;
          if (ord >= PosLimit) begin
            sat = 1'b1;
            ord = PosLimit;
          end
          expected_matches.push_back('{start[15:0], ord[15:0], sat});
          if (match_cnt < PosLimit) match_cnt++;
          k = fail_len[pat_len-1];
        end
        match_len = k;
        if (text_pos < PosLimit) text_pos++;
      end
      if (last) clear_text();
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_match(logic [15:0] start, logic [15:0] ordinal, logic sat);
      match_t m;
      matches_seen++;
      if (sat === 1'b1) sat_seen++;
      if (expected_matches.size() == 0) begin
        errors++;
        $display("%0t: unexpected match, expected none, actual start %0d index %0d sat %0b",
                 $time, start, ordinal, sat);
        return;
      end
      m = expected_matches.pop_front();
      compare_field("match_start", m.start, start);
      compare_field("match_index", m.ordinal, ordinal);
      compare_field("past_range", 16'(m.sat), 16'(sat));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        cmd_i       = 1'b0;
  logic [7:0]  char_byte_i = 8'h00;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] match_start_o;
  logic [15:0] match_index_o;
  logic        past_range_o;

  bit              quiet = 1'b0;
  int unsigned     cycle_count = 0;
  match_scoreboard sb;

  kmp_substring_matcher_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .char_byte_i  (char_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .match_start_o(match_start_o),
    .match_index_o(match_index_o),
    .past_range_o (past_range_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("cycle limit reached with %0d matches outstanding", sb.expected_matches.size());
      $display("status: fail");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_match(match_start_o, match_index_o, past_range_o);
    end
    out_stall_i <= !quiet && ($urandom_range(99) < 19);
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(kmp_op_e op, logic [7:0] chr, logic last);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= op;
    char_byte_i <= chr;
    last_i      <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(op, chr, last);
  endtask

  // stimulus
  initial begin
    int unsigned base;
    int unsigned plen;
    int unsigned tlen;
    int unsigned nsym;
    int unsigned kind;
    int unsigned pick;
    logic [7:0]  alpha [3];
    logic [7:0]  chr;

    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // text before any pattern is ignored
    send_item(OP_TEXT, 8'hFF, 1'b0);
    send_item(OP_TEXT, 8'h00, 1'b1);
    // extreme bytes, overlapping matches, match on the last text byte
    send_item(OP_PATTERN, 8'h00, 1'b0);
    send_item(OP_PATTERN, 8'hFF, 1'b0);
    send_item(OP_PATTERN, 8'h00, 1'b1);
    send_item(OP_TEXT, 8'h00, 1'b0);
    send_item(OP_TEXT, 8'hFF, 1'b0);
    send_item(OP_TEXT, 8'h00, 1'b0);
    send_item(OP_TEXT, 8'hFF, 1'b0);
    send_item(OP_TEXT, 8'h00, 1'b1);
    // new pattern after a closed one, text while the pattern is open
    send_item(OP_PATTERN, 8'h41, 1'b0);
    send_item(OP_TEXT, 8'h41, 1'b1);
    send_item(OP_PATTERN, 8'h41, 1'b1);
    send_item(OP_TEXT, 8'h41, 1'b0);
    send_item(OP_TEXT, 8'h41, 1'b0);
    send_item(OP_TEXT, 8'h41, 1'b1);
    // new pattern in the middle of a text clears the text state
    send_item(OP_TEXT, 8'h41, 1'b0);
    send_item(OP_PATTERN, 8'h80, 1'b0);
    send_item(OP_PATTERN, 8'h7F, 1'b1);
    send_item(OP_TEXT, 8'h80, 1'b0);
    send_item(OP_TEXT, 8'h7F, 1'b0);
    send_item(OP_TEXT, 8'h80, 1'b0);
    send_item(OP_TEXT, 8'h7F, 1'b1);

    // random sequences over small alphabets so that matches and failure links occur
    base = sb.items_noted;
    while (sb.items_noted - base < RandomBytes) begin
      quiet = (sb.items_noted - base >= 350) && (sb.items_noted - base < 550);
      kind  = $urandom_range(99);
      nsym  = $urandom_range(3, 1);
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(255));
      if (kind < 75) begin
        // pattern: mostly short, some long, a few past the store
        pick = $urandom_range(99);
        if (pick < 85) plen = $urandom_range(6, 1);
        else if (pick < 95) plen = $urandom_range(PatMax, 7);
        else plen = $urandom_range(PatMax + 6, PatMax + 1);
        for (int unsigned i = 0; i < plen; i++) begin
          send_item(OP_PATTERN, alpha[$urandom_range(nsym - 1)], i == plen - 1);
        end
        repeat ($urandom_range(3, 1)) begin
          tlen = $urandom_range(40, 1);
          for (int unsigned i = 0; i < tlen; i++) begin
            if ($urandom_range(9) == 0) chr = 8'($urandom_range(255));
            else chr = alpha[$urandom_range(nsym - 1)];
            send_item(OP_TEXT, chr, (i == tlen - 1) && ($urandom_range(99) < 85));
          end
        end
      end else if (kind < 90) begin
        // noise
        repeat ($urandom_range(8, 1)) begin
          send_item(kmp_op_e'($urandom_range(1)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
        end
      end else begin
        // pattern left open with text in between
        repeat ($urandom_range(3, 1)) begin
          send_item(OP_PATTERN, alpha[$urandom_range(nsym - 1)], 1'b0);
        end
        repeat ($urandom_range(4, 1)) begin
          send_item(OP_TEXT, alpha[$urandom_range(nsym - 1)], 1'($urandom_range(1)));
        end
      end
    end
    quiet = 1'b0;

    // drain
    in_valid_i <= 1'b0;
    while (sb.expected_matches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d input transfers (%0d pattern and search bytes used), %0d matches checked",
             sb.items_noted, sb.bytes_used, sb.matches_seen);
    $display("including %0d saturated results, %0d mismatches", sb.sat_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/kmp_pkg.sv
src/kmp_front.sv
src/kmp_back.sv
src/kmp_substring_matcher_top.sv
dv/tb_kmp_substring_matcher_top.sv
